// ===== sv/cfre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfre_pkg: shared types and constants
// Command codes, geometry constants and the command word passed from the
// front end to the draw back end.
// ----------------------------------------------------------------------------
package cfre_pkg;

  localparam int MaxCols = 64;
  localparam int MaxRows = 64;
  localparam int ColW    = $clog2(MaxCols);
  localparam int RowW    = $clog2(MaxRows);
  localparam int AddrW   = ColW + RowW;
  localparam int Depth   = MaxCols * MaxRows;
  localparam int CfgW    = 7;
  localparam int QDepth  = 2;

  localparam logic [7:0] SpaceCode = 8'd32;

  typedef enum logic [2:0] {
    OP_CLEAR   = 3'd0,
    OP_POINT   = 3'd1,
    OP_LINE    = 3'd2,
    OP_CIRCLE  = 3'd3,
    OP_FCIRCLE = 3'd4,
    OP_RECT    = 3'd5,
    OP_FRECT   = 3'd6,
    OP_READ    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_CLIP   = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  localparam logic CfgIdxW = 1'b0;

  // command after front-end classification
  typedef struct packed {
    op_t        op;
    logic       reject;   // line octant reject: nothing drawn
    logic [5:0] c0;
    logic [5:0] r0;
    logic [5:0] c1;
    logic [5:0] r1;
    logic [5:0] rad;
    logic [7:0] glyph;
  } cmd_t;

endpackage

// ===== sv/char_framebuffer_raster_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_framebuffer_raster_engine: character raster drawing engine
// Top level: configuration registers, command intake and draw sequencer.
// ----------------------------------------------------------------------------
// One command word in, one result word out. The draw sequencer visits one
// cell per cycle through a single-port 64x64 frame store: a clear covers
// the canvas, a circle or rectangle its bounding box, a line one cell per
// column of its span, and a read adds a wait state for the store's data.
// A two-entry queue lets new commands arrive while one is drawn. After
// reset the sequencer writes spaces into every cell before it starts the
// first command; up to two words queue meanwhile.
module char_framebuffer_raster_engine import cfre_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // op[2:0], start_col[8:3], start_row[14:9], end_col[20:15], end_row[26:21],
  // radius[32:27], glyph[40:33], zero fill [47:41]
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], read_glyph[9:2], zero fill [15:10]
  output logic [15:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  logic [CfgW-1:0] canvas_w_r, canvas_h_r;
  logic            q_valid, q_pop;
  cmd_t            q_cmd;
  logic [1:0]      st;
  logic [7:0]      rd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_w_r <= 7'd64;
      canvas_h_r <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_index == CfgIdxW) canvas_w_r <= cfg_data;
      else canvas_h_r <= cfg_data;
    end
  end

  cfre_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .op(in_tdata[2:0]), .c0(in_tdata[8:3]), .r0(in_tdata[14:9]),
    .c1(in_tdata[20:15]), .r1(in_tdata[26:21]), .rad(in_tdata[32:27]),
    .glyph(in_tdata[40:33]), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
  );

  cfre_back u_back (
    .clk(clk), .rst_n(rst_n), .canvas_w(canvas_w_r), .canvas_h(canvas_h_r),
    .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_status(st), .out_rd(rd)
  );

  assign out_tdata = {6'd0, rd, st};

  // result never reports an unknown status code
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] != 2'd3)) else $error("bad status");
  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  // a rejected command returns no byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == 2'd2 |-> out_tdata[9:2] == 8'd0)
    else $error("reject with data");

endmodule

// ===== sv/cfre_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfre_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module cfre_ram #(
  parameter int Width = 8,
  parameter int Dep   = 4096
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [$clog2(Dep)-1:0] addr,
  input  logic [Width-1:0]       wdata,
  output logic [Width-1:0]       rdata
);

  logic [Width-1:0] mem [Dep];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/cfre_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfre_front: command intake and queue
// Accepts command words, checks line octant and holds them in a small queue.
// ----------------------------------------------------------------------------
module cfre_front import cfre_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] op,
  input  logic [5:0] c0,
  input  logic [5:0] r0,
  input  logic [5:0] c1,
  input  logic [5:0] r1,
  input  logic [5:0] rad,
  input  logic [7:0] glyph,
  output logic       q_valid,
  input  logic       q_pop,
  output cmd_t       q_cmd
);

  cmd_t q_r [QDepth];
  logic wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic push;
  cmd_t cin;

  assign in_ready = (cnt_r != 2'(QDepth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_r[rp_r];

  // classify: a line must run right/down with row step no larger than col step
  always_comb begin
    cin.op     = op_t'(op);
    cin.c0     = c0;
    cin.r0     = r0;
    cin.c1     = c1;
    cin.r1     = r1;
    cin.rad    = rad;
    cin.glyph  = glyph;
    cin.reject = (op_t'(op) == OP_LINE) &&
                 ((c1 < c0) || (r1 < r0) || ((r1 - r0) > (c1 - c0)));
  end

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r] <= cin;
    end
  end

endmodule

// ===== sv/cfre_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfre_back: draw sequencer
// Walks each command one cell per cycle, writes the frame store and
// produces the result word. After reset it first writes spaces into every
// cell of the store, one cell per cycle.
// ----------------------------------------------------------------------------
module cfre_back import cfre_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [CfgW-1:0] canvas_w,
  input  logic [CfgW-1:0] canvas_h,
  input  logic            q_valid,
  output logic            q_pop,
  input  cmd_t            q_cmd,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_status,
  output logic [7:0]      out_rd
);

  typedef enum logic [2:0] {S_WIPE, S_IDLE, S_INIT, S_WALK, S_RDWAIT, S_OUT} state_t;

  state_t state_r;
  cmd_t   cmd_r;
  // signed walk coordinates, wide enough for centre +/- radius
  logic signed [8:0] i_r, j_r;
  logic signed [8:0] p_r;
  logic              clip_r, rdhit_r;
  logic [7:0]        rd_r;
  logic [1:0]        st_r;
  logic              valid_r;
  logic [12:0]       rr_r;        // radius squared
  logic [12:0]       di_r;        // (i-c0)^2 for current column
  logic [6:0]        ew_r, eh_r;  // effective canvas
  logic [AddrW-1:0]  wipe_r;      // reset fill address

  // RAM port
  logic             we;
  logic [AddrW-1:0] addr;
  logic [7:0]       wdata, rdata;

  cfre_ram #(.Width(8), .Dep(Depth)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // combinational per-cell decision
  logic signed [8:0] ci, cj, ilo, ihi, jlo, jhi;
  logic signed [8:0] dj;
  logic [12:0]       dsum;
  logic [11:0]       djsq;
  logic              hit, on_cnv, last_j, last_i, done_cell;

  always_comb begin
    ci   = i_r;
    cj   = j_r;
    dj   = j_r - $signed({3'b0, cmd_r.r0});
    djsq = 12'(dj * dj);
    dsum = di_r + {1'b0, djsq};
    on_cnv = (ci >= 0) && (cj >= 0) && (ci < $signed({2'b0, ew_r})) &&
             (cj < $signed({2'b0, eh_r}));
    ilo = $signed({3'b0, cmd_r.c0});
    jlo = $signed({3'b0, cmd_r.r0});
    ihi = $signed({3'b0, cmd_r.c1});
    jhi = $signed({3'b0, cmd_r.r1});
    hit = 1'b0;
    unique case (cmd_r.op)
      OP_CLEAR: begin
        ilo = 9'sd0; jlo = 9'sd0;
        ihi = $signed({2'b0, ew_r}) - 9'sd1;
        jhi = $signed({2'b0, eh_r}) - 9'sd1;
        hit = 1'b1;
      end
      OP_POINT, OP_READ, OP_LINE: hit = 1'b1;
      OP_CIRCLE, OP_FCIRCLE: begin
        ilo = $signed({3'b0, cmd_r.c0}) - $signed({3'b0, cmd_r.rad});
        ihi = $signed({3'b0, cmd_r.c0}) + $signed({3'b0, cmd_r.rad});
        jlo = $signed({3'b0, cmd_r.r0}) - $signed({3'b0, cmd_r.rad});
        jhi = $signed({3'b0, cmd_r.r0}) + $signed({3'b0, cmd_r.rad});
        if (cmd_r.op == OP_CIRCLE) begin
          hit = (dsum == rr_r) || (dsum == rr_r + 13'd2) ||
                ((rr_r >= 13'd2) && (dsum == rr_r - 13'd2));
        end else begin
          hit = (dsum <= rr_r);
        end
      end
      OP_RECT: hit = (cj == jlo) || (cj == jhi) || (ci == ilo) || (ci == ihi);
      OP_FRECT: hit = 1'b1;
      default: hit = 1'b1;
    endcase
    last_j = (cj >= jhi);
    last_i = (ci >= ihi);
    // single-cell commands and lines end on column; areas on both
    if (cmd_r.op == OP_POINT || cmd_r.op == OP_READ) begin
      done_cell = 1'b1;
    end else if (cmd_r.op == OP_LINE) begin
      done_cell = last_i;
    end else begin
      done_cell = last_i && last_j;
    end
  end

  // store port: reset fill, else the cell under the walk
  always_comb begin
    if (state_r == S_WIPE) begin
      addr  = wipe_r;
      wdata = SpaceCode;
      we    = 1'b1;
    end else begin
      addr  = {cj[RowW-1:0], ci[ColW-1:0]};
      wdata = (cmd_r.op == OP_CLEAR) ? SpaceCode : cmd_r.glyph;
      we    = (state_r == S_WALK) && hit && on_cnv && (cmd_r.op != OP_READ);
    end
  end

  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign out_valid  = valid_r;
  assign out_status = st_r;
  assign out_rd     = rd_r;

  logic signed [8:0] di;
  assign di = ci + 9'sd1 - $signed({3'b0, cmd_r.c0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WIPE;
      wipe_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_WIPE: begin
          wipe_r <= wipe_r + 1'b1;
          if (wipe_r == AddrW'(Depth - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cmd_r   <= q_cmd;
            clip_r  <= 1'b0;
            rd_r    <= 8'd0;
            rdhit_r <= 1'b0;
            ew_r    <= (canvas_w > 7'(MaxCols)) ? 7'(MaxCols) : canvas_w;
            eh_r    <= (canvas_h > 7'(MaxRows)) ? 7'(MaxRows) : canvas_h;
            state_r <= S_INIT;
          end
        end
        S_INIT: begin
          // one multiply for r squared, set start of walk
          rr_r <= 13'(cmd_r.rad * cmd_r.rad);
          di_r <= 13'(cmd_r.rad * cmd_r.rad);
          i_r  <= ilo;
          j_r  <= jlo;
          p_r  <= 9'sd2 * $signed({3'b0, cmd_r.r1 - cmd_r.r0}) -
                  $signed({3'b0, cmd_r.c1 - cmd_r.c0});
          if (cmd_r.reject) begin
            st_r    <= ST_REJECT;
            valid_r <= 1'b1;
            state_r <= S_OUT;
          end else if (cmd_r.op == OP_CLEAR && (ew_r == 7'd0 || eh_r == 7'd0)) begin
            st_r    <= ST_DONE;
            valid_r <= 1'b1;
            state_r <= S_OUT;
          end else if ((cmd_r.op == OP_RECT || cmd_r.op == OP_FRECT) &&
                       ((cmd_r.c0 > cmd_r.c1) || (cmd_r.r0 > cmd_r.r1))) begin
            st_r    <= ST_DONE;
            valid_r <= 1'b1;
            state_r <= S_OUT;
          end else begin
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          if (hit && !on_cnv) begin
            clip_r <= 1'b1;
          end
          if (cmd_r.op == OP_READ) begin
            rdhit_r <= on_cnv;
          end
          if (cmd_r.op == OP_LINE) begin
            i_r <= ci + 9'sd1;
            if (p_r >= 0) begin
              j_r <= cj + 9'sd1;
              p_r <= p_r + 9'sd2 * (jhi - jlo) - 9'sd2 * (ihi - ilo);
            end else begin
              p_r <= p_r + 9'sd2 * (jhi - jlo);
            end
          end else if (last_j) begin
            // next column: column-major like the circle walk
            j_r  <= jlo;
            i_r  <= ci + 9'sd1;
            di_r <= 13'(di * di);
          end else begin
            j_r <= cj + 9'sd1;
          end
          if (done_cell) begin
            state_r <= (cmd_r.op == OP_READ) ? S_RDWAIT : S_OUT;
            if (cmd_r.op != OP_READ) begin
              st_r    <= (clip_r || (hit && !on_cnv)) ? ST_CLIP : ST_DONE;
              valid_r <= 1'b1;
            end
          end
        end
        S_RDWAIT: begin
          rd_r    <= rdhit_r ? rdata : 8'd0;
          st_r    <= rdhit_r ? ST_DONE : ST_CLIP;
          valid_r <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            valid_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
